// File: design/ubd_pkg.sv
`timescale 1ns / 1ps

package ubd_pkg;

    localparam int CODE_W = 21;
    localparam logic [CODE_W-1:0] REPL_CODE_RESET = 21'h00FFFD;

    // One decoded result beat.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              repl;
        logic              run_last;
        logic              string_last;
    } ubd_result_t;

    // Everything one byte yields: zero, one or two results.
    typedef struct packed {
        logic [1:0]  cnt;
        ubd_result_t r0;
        ubd_result_t r1;
    } ubd_pair_t;

endpackage

// File: design/ubd_decode.sv
`timescale 1ns / 1ps

module ubd_decode (
    input  logic [7:0]                 byte_in,
    input  logic                       eos,
    input  logic [1:0]                 pend,
    input  logic [ubd_pkg::CODE_W-1:0] partial,
    input  logic [ubd_pkg::CODE_W-1:0] repl_code,
    output ubd_pkg::ubd_pair_t         pair,
    output logic [1:0]                 pend_next,
    output logic [ubd_pkg::CODE_W-1:0] partial_next
);
    import ubd_pkg::*;

    ubd_result_t                main0;
    ubd_result_t                main1;
    logic [1:0]                 n_main;
    logic [1:0]                 pend_after;
    logic [CODE_W-1:0]          partial_after;
    logic [CODE_W-1:0]          shifted;
    logic [1:0]                 n_all;

    assign shifted = {partial[CODE_W-7:0], byte_in[5:0]};

    // Byte class and the results it produces on its own.
    always_comb
    begin
        main0         = '0;
        main1         = '0;
        n_main        = 2'd0;
        pend_after    = pend;
        partial_after = partial;
        case (byte_in) inside
            [8'h00:8'h7F]:
            begin
                pend_after = 2'd0;
                if (pend != 2'd0)
                begin
                    main0.code = repl_code;
                    main0.repl = 1'b1;
                    main1.code = {13'd0, byte_in};
                    n_main     = 2'd2;
                end
                else
                begin
                    main0.code = {13'd0, byte_in};
                    n_main     = 2'd1;
                end
            end
            [8'h80:8'hBF]:
            begin
                if (pend != 2'd0)
                begin
                    partial_after = shifted;
                    pend_after    = pend - 2'd1;
                    if (pend == 2'd1)
                    begin
                        main0.code = shifted;
                        n_main     = 2'd1;
                    end
                end
                else
                begin
                    main0.code = repl_code;
                    main0.repl = 1'b1;
                    n_main     = 2'd1;
                end
            end
            [8'hC0:8'hDF]:
            begin
                pend_after    = 2'd1;
                partial_after = {16'd0, byte_in[4:0]};
            end
            [8'hE0:8'hEF]:
            begin
                pend_after    = 2'd2;
                partial_after = {17'd0, byte_in[3:0]};
            end
            [8'hF0:8'hF7]:
            begin
                pend_after    = 2'd3;
                partial_after = {18'd0, byte_in[2:0]};
            end
            default:
            begin
                main0.code = repl_code;
                main0.repl = 1'b1;
                n_main     = 2'd1;
                pend_after = 2'd0;
            end
        endcase
    end

    // Truncation at end of string, then the last-beat flags.
    always_comb
    begin
        pair.r0 = main0;
        pair.r1 = main1;
        n_all   = n_main;
        if (eos && pend_after != 2'd0)
        begin
            if (n_main == 2'd0)
            begin
                pair.r0.code = repl_code;
                pair.r0.repl = 1'b1;
            end
            else
            begin
                pair.r1.code = repl_code;
                pair.r1.repl = 1'b1;
            end
            n_all = n_main + 2'd1;
        end
        if (n_all == 2'd1)
        begin
            pair.r0.run_last    = 1'b1;
            pair.r0.string_last = eos;
        end
        else if (n_all == 2'd2)
        begin
            pair.r1.run_last    = 1'b1;
            pair.r1.string_last = eos;
        end
        pair.cnt     = n_all;
        pend_next    = eos ? 2'd0 : pend_after;
        partial_next = eos ? '0 : partial_after;
    end

endmodule

// File: design/ubd_out_buf.sv
`timescale 1ns / 1ps

module ubd_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ubd_pkg::ubd_pair_t  pair,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_stall,
    output ubd_pkg::ubd_result_t head
);
    import ubd_pkg::*;

    ubd_result_t slot0_reg, slot0_next;
    ubd_result_t slot1_reg, slot1_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && !out_stall);
    assign head      = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (load)
        begin
            slot0_next = pair.r0;
            slot1_next = pair.r1;
            cnt_next   = pair.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// File: design/utf8_byte_decoder_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Beat payload
// -------  ---  -------------------  -------------------------------------------------
// in       in   in_valid / in_stall  byte_in, end_of_string
// out      out  out_valid/out_stall  code_point, is_replacement, run_last, string_last
// cfg      in   cfg_wr_en            cfg_wr_data (replacement code, 21 bits)
//
// A byte lands in the input register, is decoded combinationally against the
// pending count and partial code, and its results go to a two-slot result
// buffer. One byte per cycle while the output does not stall; a byte that
// yields two results holds the buffer for two output beats and holds off the
// next byte. Results pass the input register, then the result buffer. Reset
// clears the decode state and both valid flags; the replacement code resets to
// 0xFFFD. Output stall backs up into in_stall once the input register is full.

module utf8_byte_decoder_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [ubd_pkg::CODE_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 byte_in,
    input  logic                       end_of_string,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ubd_pkg::CODE_W-1:0] code_point,
    output logic                       is_replacement,
    output logic                       run_last,
    output logic                       string_last
);
    import ubd_pkg::*;

    logic [CODE_W-1:0] repl_code_reg;

    // Input register
    logic              in_full_reg, in_full_next;
    logic [7:0]        byte_reg, byte_next;
    logic              eos_reg, eos_next;

    // Decode state
    logic [1:0]        pend_reg, pend_next;
    logic [CODE_W-1:0] partial_reg, partial_next;
    logic [1:0]        dec_pend;
    logic [CODE_W-1:0] dec_partial;

    ubd_pair_t         pair;
    ubd_result_t       head;
    logic              can_load;
    logic              advance;
    logic              in_take;

    // Byte leaves the input register once the buffer can take its results.
    assign advance  = in_full_reg && can_load;
    assign in_stall = in_full_reg && !can_load;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        byte_next    = byte_reg;
        eos_next     = eos_reg;
        pend_next    = pend_reg;
        partial_next = partial_reg;
        if (advance)
        begin
            in_full_next = 1'b0;
            pend_next    = dec_pend;
            partial_next = dec_partial;
        end
        if (in_take)
        begin
            in_full_next = 1'b1;
            byte_next    = byte_in;
            eos_next     = end_of_string;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_code_reg <= REPL_CODE_RESET;
            in_full_reg   <= 1'b0;
            pend_reg      <= 2'd0;
            partial_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                repl_code_reg <= cfg_wr_data;
            end
            in_full_reg <= in_full_next;
            pend_reg    <= pend_next;
            partial_reg <= partial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eos_reg  <= eos_next;
    end

    ubd_decode u_decode (
        .byte_in      (byte_reg),
        .eos          (eos_reg),
        .pend         (pend_reg),
        .partial      (partial_reg),
        .repl_code    (repl_code_reg),
        .pair         (pair),
        .pend_next    (dec_pend),
        .partial_next (dec_partial)
    );

    // Zero-result bytes (lead bytes and unfinished continuation bytes mid-string) advance without a load.
    ubd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && pair.cnt != 2'd0),
        .pair      (pair),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign code_point     = head.code;
    assign is_replacement = head.repl;
    assign run_last       = head.run_last;
    assign string_last    = head.string_last;

endmodule

// File: verif/tb_utf8_byte_decoder_top.sv
`timescale 1ns / 1ps

// Byte-stream test of the UTF-8 decoder: directed corner strings, then random
// strings built mostly from well-formed sequences, checked beat by beat
// against a cycle-free model of the decode state.
module tb_utf8_byte_decoder_top;

    import ubd_pkg::*;

    // Byte class boundaries of UTF-8.
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MAX = 8'hF7;
    localparam logic [7:0] LEAD2_TAG = 8'hC0;
    localparam logic [7:0] LEAD3_TAG = 8'hE0;
    localparam logic [7:0] LEAD4_TAG = 8'hF0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] HIGH_MIN  = 8'hF8;
    localparam logic [7:0] HIGH_MAX  = 8'hFF;

    localparam int CODE_MAX     = 21'h1FFFFF;
    localparam int PIPE_SETTLE  = 4;       // > input-to-result latency
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_CHUNK = 260;     // five chunks, ~1300 random bytes

    // ------------------------------------------------------------------
    // Scoreboard: tracks the decoder's pending count and partial code and
    // queues the result beats each accepted byte must produce.
    // ------------------------------------------------------------------
    class utf8_scoreboard;
        logic [CODE_W-1:0] repl_code;
        logic [1:0]        pend_cnt;
        logic [CODE_W-1:0] partial;
        ubd_result_t       exp_q[$];
        int                errors;

        function new();
            repl_code = REPL_CODE_RESET;
            pend_cnt  = 2'd0;
            partial   = '0;
            errors    = 0;
        endfunction

        function ubd_result_t make_res(logic [CODE_W-1:0] code, logic repl);
            ubd_result_t r;
            r.code        = code;
            r.repl        = repl;
            r.run_last    = 1'b0;
            r.string_last = 1'b0;
            return r;
        endfunction

        // Advance the decode state by one byte and queue what it yields.
        function void decode_byte(logic [7:0] b, logic eos);
            ubd_result_t res[$];
            if (b <= ASCII_MAX)
            begin
                // ASCII cuts off a pending sequence: replacement goes first
                if (pend_cnt != 2'd0)
                begin
                    res.insert(res.size(), make_res(repl_code, 1'b1));
                    pend_cnt = 2'd0;
                end
                res.insert(res.size(), make_res({13'd0, b}, 1'b0));
            end
            else if (b <= CONT_MAX)
            begin
                if (pend_cnt != 2'd0)
                begin
                    partial  = {partial[CODE_W-7:0], b[5:0]};
                    pend_cnt = pend_cnt - 2'd1;
                    if (pend_cnt == 2'd0)
                        res.insert(res.size(), make_res(partial, 1'b0));
                end
                else
                    res.insert(res.size(), make_res(repl_code, 1'b1));
            end
            else if (b <= LEAD2_MAX)
            begin
                pend_cnt = 2'd1;
                partial  = {16'd0, b[4:0]};
            end
            else if (b <= LEAD3_MAX)
            begin
                pend_cnt = 2'd2;
                partial  = {17'd0, b[3:0]};
            end
            else if (b <= LEAD4_MAX)
            begin
                pend_cnt = 2'd3;
                partial  = {18'd0, b[2:0]};
            end
            else
            begin
                res.insert(res.size(), make_res(repl_code, 1'b1));
                pend_cnt = 2'd0;
            end

            if (eos)
            begin
                if (pend_cnt != 2'd0)
                    res.insert(res.size(), make_res(repl_code, 1'b1));
                pend_cnt = 2'd0;
                partial  = '0;
            end

            if (res.size() > 0)
            begin
                res[res.size()-1].run_last    = 1'b1;
                res[res.size()-1].string_last = eos;
            end
            foreach (res[i])
                exp_q.insert(exp_q.size(), res[i]);
        endfunction

        function void check_beat(logic [CODE_W-1:0] cp, logic rp, logic rl, logic sl);
            ubd_result_t want;
            if (exp_q.size() == 0)
            begin
                $error("unexpected result beat: code_point %06h", cp);
                errors++;
                return;
            end
            want = exp_q.pop_front();
            if (cp !== want.code)
            begin
                $error("code_point: expected %06h, actual %06h", want.code, cp);
                errors++;
            end
            if (rp !== want.repl)
            begin
                $error("is_replacement: expected %0b, actual %0b", want.repl, rp);
                errors++;
            end
            if (rl !== want.run_last)
            begin
                $error("run_last: expected %0b, actual %0b", want.run_last, rl);
                errors++;
            end
            if (sl !== want.string_last)
            begin
                $error("string_last: expected %0b, actual %0b", want.string_last, sl);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [CODE_W-1:0] cfg_wr_data   = '0;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic [7:0]        byte_in       = 8'd0;
    logic              end_of_string = 1'b0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic [CODE_W-1:0] code_point;
    logic              is_replacement;
    logic              run_last;
    logic              string_last;

    utf8_byte_decoder_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_in        (byte_in),
        .end_of_string  (end_of_string),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code_point     (code_point),
        .is_replacement (is_replacement),
        .run_last       (run_last),
        .string_last    (string_last)
    );

    utf8_scoreboard sb;

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop in case the handshake locks up.
    int cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Beat monitor. Sampled at the rising edge, before the DUT's own updates
    // land. Results are checked before the same-edge input is noted; they
    // follow the input register and result buffer, so never belong to it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_beat(code_point, is_replacement, run_last, string_last);
            if (in_valid && !in_stall)
                sb.decode_byte(byte_in, end_of_string);
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: a mode is picked at random and held for a
    // while, so there are open stretches, light and heavy random stall,
    // and a fixed 3-of-7 pattern that walks across the two-beat pairs.
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {ST_NONE, ST_LIGHT, ST_HEAVY, ST_PERIODIC} stall_mode_t;

    stall_mode_t stall_mode = ST_NONE;
    int          mode_left  = 0;
    int          stall_tick = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(64, 256);
        end
        else
            mode_left <= mode_left - 1;
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            ST_NONE:     out_stall <= 1'b0;
            ST_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            ST_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            ST_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
            default:     out_stall <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0] b;
        logic       eos;
    } tx_beat_t;

    typedef enum int {TK_ASCII, TK_SEQ, TK_TRUNC, TK_STRAY, TK_HIGH, TK_ANY} token_kind_t;

    tx_beat_t tx_q[$];

    function void push_beat(logic [7:0] b, logic eos);
        tx_beat_t t;
        t.b   = b;
        t.eos = eos;
        tx_q.insert(tx_q.size(), t);
    endfunction

    // One token of a string: a character, a (possibly cut short) multi-byte
    // sequence, or a malformed byte.
    function void add_token(token_kind_t k);
        int n;
        int keep;
        n = $urandom_range(2, 4);
        case (k)
            TK_ASCII: push_beat(8'($urandom_range(0, ASCII_MAX)), 1'b0);
            TK_SEQ, TK_TRUNC:
            begin
                keep = (k == TK_SEQ) ? n - 1 : $urandom_range(0, n - 2);
                case (n)
                    2:       push_beat(LEAD2_TAG | 8'($urandom_range(0, 31)), 1'b0);
                    3:       push_beat(LEAD3_TAG | 8'($urandom_range(0, 15)), 1'b0);
                    default: push_beat(LEAD4_TAG | 8'($urandom_range(0, 7)), 1'b0);
                endcase
                repeat (keep)
                    push_beat(CONT_TAG | 8'($urandom_range(0, 63)), 1'b0);
            end
            TK_STRAY: push_beat(CONT_TAG | 8'($urandom_range(0, 63)), 1'b0);
            TK_HIGH:  push_beat(8'($urandom_range(HIGH_MIN, HIGH_MAX)), 1'b0);
            default:  push_beat(8'($urandom_range(0, 255)), 1'b0);
        endcase
    endfunction

    // Random strings of 1..8 tokens; about 70% of tokens are well formed.
    function void build_strings(int target);
        int pick;
        int nt;
        while (tx_q.size() < target)
        begin
            nt = $urandom_range(1, 8);
            repeat (nt)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)      add_token(TK_ASCII);
                else if (pick < 70) add_token(TK_SEQ);
                else if (pick < 80) add_token(TK_TRUNC);
                else if (pick < 88) add_token(TK_STRAY);
                else if (pick < 94) add_token(TK_HIGH);
                else                add_token(TK_ANY);
            end
            tx_q[tx_q.size()-1].eos = 1'b1;
        end
    endfunction

    // Corner strings: ASCII extremes, shortest and longest forms, every
    // malformed case, the drop of an unfinished sequence by a new lead, and
    // end of string with a sequence still open.
    function void build_directed();
        push_beat(8'h00, 1'b0);
        push_beat(8'h7F, 1'b1);
        push_beat(8'hC0, 1'b0); push_beat(8'h80, 1'b0);               // 0x000000
        push_beat(8'hDF, 1'b0); push_beat(8'hBF, 1'b0);               // 0x0007FF
        push_beat(8'hEF, 1'b0); push_beat(8'hBF, 1'b0); push_beat(8'hBF, 1'b0);
        push_beat(8'hF7, 1'b0); push_beat(8'hBF, 1'b0);               // 0x1FFFFF
        push_beat(8'hBF, 1'b0); push_beat(8'hBF, 1'b1);
        push_beat(8'h80, 1'b0);                                       // stray
        push_beat(8'hF8, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hE2, 1'b0); push_beat(8'h41, 1'b1);               // ASCII cut
        push_beat(8'hC3, 1'b0); push_beat(8'hE2, 1'b0);               // lead drop
        push_beat(8'h82, 1'b0); push_beat(8'hAC, 1'b0);
        push_beat(8'hF0, 1'b0); push_beat(8'h9F, 1'b1);               // open at end
        push_beat(8'hF0, 1'b0); push_beat(8'hFF, 1'b1);               // high in seq
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything moves on the falling edge; a beat is done at the
    // first rising edge with in_stall low.
    // ------------------------------------------------------------------
    task automatic drive_beat(tx_beat_t t);
        @(negedge clk);
        in_valid      <= 1'b1;
        byte_in       <= t.b;
        end_of_string <= t.eos;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_sender(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Stop sending and hold off until every queued result has come back.
    task automatic wait_drained();
        idle_sender(1);
        while (sb.exp_q.size() != 0)
            @(posedge clk);
    endtask

    // Bursts of random length, mostly short, with the odd long run;
    // sometimes the source holds back until the decoder has drained.
    task automatic send_all();
        int burst;
        while (tx_q.size() > 0)
        begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                                : $urandom_range(1, 12);
            while (burst > 0 && tx_q.size() > 0)
            begin
                drive_beat(tx_q.pop_front());
                burst--;
            end
            if ($urandom_range(0, 19) == 0)
                wait_drained();
            else
                idle_sender($urandom_range(0, 5));
        end
    endtask

    // Register writes only on an idle decoder: a lead byte yields nothing,
    // so wait out the pipe after the last result as well.
    task automatic write_repl(logic [CODE_W-1:0] code);
        wait_drained();
        repeat (PIPE_SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.repl_code = code;
    endtask

    task automatic random_phase();
        build_strings(RANDOM_CHUNK);
        send_all();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value of the replacement code first
        build_directed();
        send_all();

        write_repl('0);
        random_phase();

        write_repl(CODE_W'(CODE_MAX));
        build_directed();
        send_all();
        random_phase();

        write_repl(CODE_W'($urandom_range(0, CODE_MAX)));
        random_phase();

        // a code that looks like an ASCII character
        write_repl(CODE_W'($urandom_range(0, ASCII_MAX)));
        random_phase();

        write_repl(REPL_CODE_RESET);
        random_phase();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.exp_q.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.exp_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
